// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/chp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

  localparam int DATA_W             = 8;
  localparam int FIXED_HEADER_BYTES = 4;
  localparam int HDR_POS_W          = $clog2(FIXED_HEADER_BYTES);

  localparam logic [3:0] MAX_TOKEN    = 4'd8;
  localparam logic [1:0] COAP_VERSION = 2'd1;
  localparam logic [7:0] MARKER_BYTE  = 8'hff;
  localparam logic [3:0] NIB_RSVD     = 4'hf;
  localparam logic [3:0] NIB_EXT1     = 4'd13;
  localparam logic [3:0] NIB_EXT2     = 4'd14;
  localparam logic [15:0] EXT1_BASE   = 16'd13;
  localparam logic [15:0] EXT2_BASE   = 16'd269;

  localparam logic [2:0] CLS_FIXED   = 3'd0;
  localparam logic [2:0] CLS_TOKEN   = 3'd1;
  localparam logic [2:0] CLS_OPT_HDR = 3'd2;
  localparam logic [2:0] CLS_EXT     = 3'd3;
  localparam logic [2:0] CLS_VALUE   = 3'd4;
  localparam logic [2:0] CLS_MARKER  = 3'd5;
  localparam logic [2:0] CLS_PAYLOAD = 3'd6;
  localparam logic [2:0] CLS_IGNORED = 3'd7;

  localparam logic [1:0] STAT_PARSING = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_ERROR   = 2'd2;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic        option_ready;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [1:0]  message_type;
    logic [3:0]  token_count;
    logic [7:0]  header_code;
    logic [15:0] message_id;
    logic [1:0]  status;
  } chp_result_t;

endpackage

`default_nettype wire

// File: rtl/chp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module chp_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [chp_pkg::DATA_W-1:0] in_tdata,
  input  wire logic                       in_tlast,
  input  wire logic                       step,
  output logic                            req_vld,
  output logic [chp_pkg::DATA_W-1:0]      req_byte,
  output logic                            req_last
);
  import chp_pkg::*;

  logic              vld_r;
  logic [DATA_W-1:0] byte_r;
  logic              last_r;

  assign in_tready = !vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign req_vld  = vld_r;
  assign req_byte = byte_r;
  assign req_last = last_r;

endmodule

`default_nettype wire

// File: rtl/chp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module chp_parse_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [chp_pkg::DATA_W-1:0] data_byte,
  input  wire logic                       last_byte,
  output chp_pkg::chp_result_t            result
);
  import chp_pkg::*;

  localparam logic [3:0] PH_HDR     = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_DEXT1   = 4'd3;
  localparam logic [3:0] PH_DEXT2H  = 4'd4;
  localparam logic [3:0] PH_DEXT2L  = 4'd5;
  localparam logic [3:0] PH_LEXT1   = 4'd6;
  localparam logic [3:0] PH_LEXT2H  = 4'd7;
  localparam logic [3:0] PH_LEXT2L  = 4'd8;
  localparam logic [3:0] PH_VALUE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_ERROR   = 4'd11;

  localparam logic [HDR_POS_W-1:0] HDR_LAST_POS = HDR_POS_W'(FIXED_HEADER_BYTES - 1);

  logic [3:0]  phase_r,    phase_nxt;
  logic [15:0] count_r,    count_nxt;
  logic [7:0]  ext_high_r, ext_high_nxt;
  logic [3:0]  len_nib_r,  len_nib_nxt;
  logic [15:0] delta_r,    delta_nxt;
  logic [15:0] number_r,   number_nxt;
  logic [15:0] length_r,   length_nxt;
  logic [31:0] hdr_r,      hdr_nxt;
  logic [1:0]  status_r,   status_nxt;

  logic [2:0]  cls;
  logic        ready;
  logic        do_delta;
  logic [15:0] delta_v;
  logic [3:0]  len_nib_v;
  logic        do_finish;
  logic [15:0] length_v;
  logic [15:0] ext1_val;
  logic [15:0] ext2_val;
  logic [HDR_POS_W-1:0] pos;
  logic [1:0]  status_out;

  assign ext1_val = EXT1_BASE + {8'h00, data_byte};
  assign ext2_val = EXT2_BASE + {ext_high_r, data_byte};
  assign pos      = count_r[HDR_POS_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    ext_high_nxt = ext_high_r;
    len_nib_nxt  = len_nib_r;
    delta_nxt    = delta_r;
    number_nxt   = number_r;
    length_nxt   = length_r;
    hdr_nxt      = hdr_r;
    status_nxt   = status_r;
    cls          = CLS_IGNORED;
    ready        = 1'b0;
    do_delta     = 1'b0;
    delta_v      = delta_r;
    len_nib_v    = len_nib_r;
    do_finish    = 1'b0;
    length_v     = length_r;

    unique case (phase_r)
      PH_HDR: begin
        cls = CLS_FIXED;
        case (pos)
          2'd0:    hdr_nxt[31:24] = hdr_r[31:24] | data_byte;
          2'd1:    hdr_nxt[23:16] = hdr_r[23:16] | data_byte;
          2'd2:    hdr_nxt[15:8]  = hdr_r[15:8]  | data_byte;
          default: hdr_nxt[7:0]   = hdr_r[7:0]   | data_byte;
        endcase
        if (pos == '0 && (data_byte[7:6] != COAP_VERSION || data_byte[3:0] > MAX_TOKEN)) begin
          status_nxt = STAT_ERROR;
          phase_nxt  = PH_ERROR;
        end else if (pos == HDR_LAST_POS) begin
          count_nxt = {12'h000, hdr_r[27:24]};
          phase_nxt = (hdr_r[27:24] == 4'd0) ? PH_OPT : PH_TOKEN;
        end else begin
          count_nxt = count_r + 16'd1;
        end
      end
      PH_TOKEN: begin
        cls       = CLS_TOKEN;
        count_nxt = count_r - 16'd1;
        if (count_r == 16'd1) begin
          phase_nxt = PH_OPT;
        end
      end
      PH_OPT: begin
        if (data_byte == MARKER_BYTE) begin
          cls        = CLS_MARKER;
          status_nxt = STAT_OK;
          phase_nxt  = PH_PAYLOAD;
        end else begin
          cls         = CLS_OPT_HDR;
          len_nib_nxt = data_byte[3:0];
          if (data_byte[7:4] == NIB_RSVD || data_byte[3:0] == NIB_RSVD) begin
            status_nxt = STAT_ERROR;
            phase_nxt  = PH_ERROR;
          end else if (data_byte[7:4] == NIB_EXT1) begin
            phase_nxt = PH_DEXT1;
          end else if (data_byte[7:4] == NIB_EXT2) begin
            phase_nxt = PH_DEXT2H;
          end else begin
            do_delta  = 1'b1;
            delta_v   = {12'h000, data_byte[7:4]};
            len_nib_v = data_byte[3:0];
          end
        end
      end
      PH_DEXT1: begin
        cls      = CLS_EXT;
        do_delta = 1'b1;
        delta_v  = ext1_val;
      end
      PH_DEXT2H: begin
        cls          = CLS_EXT;
        ext_high_nxt = data_byte;
        phase_nxt    = PH_DEXT2L;
      end
      PH_DEXT2L: begin
        cls      = CLS_EXT;
        do_delta = 1'b1;
        delta_v  = ext2_val;
      end
      PH_LEXT1: begin
        cls       = CLS_EXT;
        do_finish = 1'b1;
        length_v  = ext1_val;
      end
      PH_LEXT2H: begin
        cls          = CLS_EXT;
        ext_high_nxt = data_byte;
        phase_nxt    = PH_LEXT2L;
      end
      PH_LEXT2L: begin
        cls       = CLS_EXT;
        do_finish = 1'b1;
        length_v  = ext2_val;
      end
      PH_VALUE: begin
        cls       = CLS_VALUE;
        count_nxt = count_r - 16'd1;
        if (count_r == 16'd1) begin
          phase_nxt = PH_OPT;
        end
      end
      PH_PAYLOAD: begin
        cls = CLS_PAYLOAD;
      end
      default: begin
        cls       = CLS_IGNORED;
        phase_nxt = PH_ERROR;
      end
    endcase

    if (do_delta) begin
      delta_nxt = delta_v;
      if (len_nib_v == NIB_EXT1) begin
        phase_nxt = PH_LEXT1;
      end else if (len_nib_v == NIB_EXT2) begin
        phase_nxt = PH_LEXT2H;
      end else begin
        do_finish = 1'b1;
        length_v  = {12'h000, len_nib_v};
      end
    end

    if (do_finish) begin
      number_nxt = number_r + delta_nxt;
      length_nxt = length_v;
      ready      = 1'b1;
      if (length_v == 16'd0) begin
        phase_nxt = PH_OPT;
      end else begin
        count_nxt = length_v;
        phase_nxt = PH_VALUE;
      end
    end

    status_out = (last_byte && phase_nxt != PH_PAYLOAD) ? STAT_ERROR : status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r    <= PH_HDR;
      count_r    <= '0;
      ext_high_r <= '0;
      len_nib_r  <= '0;
      delta_r    <= '0;
      number_r   <= '0;
      length_r   <= '0;
      hdr_r      <= '0;
      status_r   <= STAT_PARSING;
    end else if (step) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      ext_high_r <= ext_high_nxt;
      len_nib_r  <= len_nib_nxt;
      delta_r    <= delta_nxt;
      number_r   <= number_nxt;
      length_r   <= length_nxt;
      hdr_r      <= hdr_nxt;
      status_r   <= status_nxt;
    end
  end

  always_comb begin
    result.byte_class    = cls;
    result.option_ready  = ready;
    result.option_number = ready ? number_nxt : 16'd0;
    result.option_length = ready ? length_nxt : 16'd0;
    result.message_type  = hdr_nxt[29:28];
    result.token_count   = hdr_nxt[27:24];
    result.header_code   = hdr_nxt[23:16];
    result.message_id    = hdr_nxt[15:0];
    result.status        = status_out;
  end

endmodule

`default_nettype wire

// File: rtl/chp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module chp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_vld,
  input  wire chp_pkg::chp_result_t result,
  output logic                      has_room,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output chp_pkg::chp_result_t      out_result
);
  import chp_pkg::*;

  logic        vld_r;
  chp_result_t res_r;

  assign has_room = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (has_room) begin
      vld_r <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (has_room && req_vld) begin
      res_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

// File: rtl/coap_header_parser_unit.sv
// Channel | Dir | tdata                       | tuser / tlast
// in_     | in  | data_byte                   | tlast = last_byte
// out_    | out | option, header, status bits | tuser = byte_class, option_ready
//
// One message byte per cycle sustained while out_tready is high.
// The input register and the result register each hold one request; the parser state
// updates, and out_tvalid rises, when a request moves from the first to the second.
// Synchronous active-low reset clears the valid flags of both registers and the parser state.
// A stalled out_tready holds the result; in_tready drops while both registers are full
// and out_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module coap_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [15:0] option_number, [31:16] option_length,
                                       // [33:32] message_type, [37:34] token_count,
                                       // [45:38] header_code, [61:46] message_id,
                                       // [63:62] status
  output logic [3:0]       out_tuser   // [2:0] byte_class, [3] option_ready
);
  import chp_pkg::*;

  logic              req_vld;
  logic [DATA_W-1:0] req_byte;
  logic              req_last;
  logic              has_room;
  logic              step;
  chp_result_t       result;
  chp_result_t       out_result;

  assign step = req_vld && has_room;

  chp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .step      (step),
    .req_vld   (req_vld),
    .req_byte  (req_byte),
    .req_last  (req_last)
  );

  chp_parse_core u_parse_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (req_byte),
    .last_byte (req_last),
    .result    (result)
  );

  chp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_vld    (req_vld),
    .result     (result),
    .has_room   (has_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {out_result.status,
                      out_result.message_id,
                      out_result.header_code,
                      out_result.token_count,
                      out_result.message_type,
                      out_result.option_length,
                      out_result.option_number};
  assign out_tuser = {out_result.option_ready, out_result.byte_class};

endmodule

`default_nettype wire

// File: rtl/chp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module chp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [3:0]  out_tuser
);
  import chp_pkg::*;

  logic [2:0] cls;
  logic       opt_rdy;
  logic [1:0] stat;

  assign cls     = out_tuser[2:0];
  assign opt_rdy = out_tuser[3];
  assign stat    = out_tdata[63:62];

  `CHP_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  `CHP_ASSERT_NOW(a_opt_cls, clk, rst_n, out_tvalid && opt_rdy,
    cls == CLS_OPT_HDR || cls == CLS_EXT, "option reported on wrong byte class")

  `CHP_ASSERT_NOW(a_opt_zero, clk, rst_n, out_tvalid && !opt_rdy,
    out_tdata[31:0] == 32'd0, "option fields nonzero without option_ready")

  `CHP_ASSERT_NOW(a_ignored_err, clk, rst_n, out_tvalid && cls == CLS_IGNORED,
    stat == STAT_ERROR, "ignored byte without error status")

  `CHP_ASSERT_NOW(a_payload_ok, clk, rst_n,
    out_tvalid && (cls == CLS_MARKER || cls == CLS_PAYLOAD),
    stat == STAT_OK, "marker or payload without ok status")

endmodule

bind coap_header_parser_unit chp_checker u_chp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: tb/coap_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module coap_header_parser_unit_tb;
  import chp_pkg::*;

  localparam int RANDOM_ITEMS = 1800;

  typedef enum logic [3:0] {
    S_HEADER, S_TOKEN, S_OPT_HDR, S_DELTA_EXT1, S_DELTA_EXT2_HI, S_DELTA_EXT2_LO,
    S_LEN_EXT1, S_LEN_EXT2_HI, S_LEN_EXT2_LO, S_VALUE, S_PAYLOAD, S_ERROR
  } parse_state_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    logic [2:0] cls;
    logic [1:0] st;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;

  coap_header_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser shadow state
  parse_state_t p_state;
  logic [15:0]  p_count;
  logic [7:0]   p_ext_hi;
  logic [3:0]   p_len_nib;
  logic [15:0]  p_delta;
  logic [15:0]  p_number;
  logic [15:0]  p_length;
  logic [31:0]  p_hdr;
  logic [1:0]   p_status;
  bit           p_ready;

  chp_result_t  pending_byte_results[$];
  logic [7:0]   msg_bytes[$];
  bit           quiet = 1'b0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           mismatches = 0;
  int           messages_ok = 0;
  int           messages_bad = 0;
  int           options_decoded = 0;

  function void clear_parser();
    p_state  = S_HEADER;
    p_count  = '0;
    p_ext_hi = '0;
    p_len_nib = '0;
    p_delta  = '0;
    p_number = '0;
    p_length = '0;
    p_hdr    = '0;
    p_status = STAT_PARSING;
  endfunction

  function void close_option();
    p_number = p_number + p_delta;
    p_ready = 1'b1;
    if (p_length == 16'd0) begin
      p_state = S_OPT_HDR;
    end else begin
      p_count = p_length;
      p_state = S_VALUE;
    end
  endfunction

  function void take_length();
    if (p_len_nib == NIB_EXT1) begin
      p_state = S_LEN_EXT1;
    end else if (p_len_nib == NIB_EXT2) begin
      p_state = S_LEN_EXT2_HI;
    end else begin
      p_length = 16'(p_len_nib);
      close_option();
    end
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic l, output chp_result_t r);
    logic [2:0] cls;
    logic [1:0] pos;
    cls = CLS_IGNORED;
    p_ready = 1'b0;
    case (p_state)
      S_HEADER: begin
        pos = p_count[1:0];
        cls = CLS_FIXED;
        p_hdr = p_hdr | (32'(b) << (24 - 8 * pos));
        if (pos == 2'd0 && (b[7:6] != COAP_VERSION || b[3:0] > MAX_TOKEN)) begin
          p_status = STAT_ERROR;
          p_state = S_ERROR;
        end else begin
          p_count = p_count + 16'd1;
          if (p_count >= FIXED_HEADER_BYTES) begin
            p_count = 16'(p_hdr[27:24]);
            p_state = (p_count == 16'd0) ? S_OPT_HDR : S_TOKEN;
          end
        end
      end
      S_TOKEN: begin
        cls = CLS_TOKEN;
        p_count = p_count - 16'd1;
        if (p_count == 16'd0) p_state = S_OPT_HDR;
      end
      S_OPT_HDR: begin
        if (b == MARKER_BYTE) begin
          cls = CLS_MARKER;
          p_status = STAT_OK;
          p_state = S_PAYLOAD;
        end else begin
          cls = CLS_OPT_HDR;
          p_len_nib = b[3:0];
          if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) begin
            p_status = STAT_ERROR;
            p_state = S_ERROR;
          end else if (b[7:4] == NIB_EXT1) begin
            p_state = S_DELTA_EXT1;
          end else if (b[7:4] == NIB_EXT2) begin
            p_state = S_DELTA_EXT2_HI;
          end else begin
            p_delta = 16'(b[7:4]);
            take_length();
          end
        end
      end
      S_DELTA_EXT1: begin
        cls = CLS_EXT;
        p_delta = EXT1_BASE + 16'(b);
        take_length();
      end
      S_DELTA_EXT2_HI, S_LEN_EXT2_HI: begin
        cls = CLS_EXT;
        p_ext_hi = b;
        p_state = (p_state == S_DELTA_EXT2_HI) ? S_DELTA_EXT2_LO : S_LEN_EXT2_LO;
      end
      S_DELTA_EXT2_LO: begin
        cls = CLS_EXT;
        p_delta = EXT2_BASE + {p_ext_hi, b};
        take_length();
      end
      S_LEN_EXT1: begin
        cls = CLS_EXT;
        p_length = EXT1_BASE + 16'(b);
        close_option();
      end
      S_LEN_EXT2_LO: begin
        cls = CLS_EXT;
        p_length = EXT2_BASE + {p_ext_hi, b};
        close_option();
      end
      S_VALUE: begin
        cls = CLS_VALUE;
        p_count = p_count - 16'd1;
        if (p_count == 16'd0) p_state = S_OPT_HDR;
      end
      S_PAYLOAD: cls = CLS_PAYLOAD;
      default: begin
        cls = CLS_IGNORED;
        p_state = S_ERROR;
      end
    endcase
    if (l && p_state != S_PAYLOAD) p_status = STAT_ERROR;

    r.byte_class    = cls;
    r.option_ready  = p_ready;
    r.option_number = p_ready ? p_number : 16'd0;
    r.option_length = p_ready ? p_length : 16'd0;
    r.message_type  = p_hdr[29:28];
    r.token_count   = p_hdr[27:24];
    r.header_code   = p_hdr[23:16];
    r.message_id    = p_hdr[15:0];
    r.status        = p_status;

    if (p_ready) options_decoded++;
    if (l) begin
      if (p_status == STAT_OK) messages_ok++;
      else messages_bad++;
      clear_parser();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed = 1'b0,
                           input logic [2:0] cls = CLS_FIXED,
                           input logic [1:0] st = STAT_PARSING);
    chp_result_t r;
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, l, r);
    if (typed) begin
      r.byte_class = cls;
      r.status = st;
    end
    pending_byte_results.push_back(r);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_byte_results.size() != 0);
  endtask

  // message with random content built from valid fields; the payload marker is sometimes left out
  task automatic compose_message();
    int n_opt;
    int vlen;
    int k;
    logic [3:0] tkl;
    logic [3:0] dnib;
    logic [3:0] lnib;
    logic [7:0] dext[$];
    logic [7:0] lext[$];
    msg_bytes.delete();
    tkl = 4'($urandom_range(0, MAX_TOKEN));
    msg_bytes.push_back({COAP_VERSION, 2'($urandom_range(0, 3)), tkl});
    repeat (3 + tkl) msg_bytes.push_back(8'($urandom));
    n_opt = $urandom_range(0, 4);
    repeat (n_opt) begin
      dext.delete();
      lext.delete();
      k = $urandom_range(0, 99);
      if (k < 50) begin
        dnib = 4'($urandom_range(0, 12));
      end else if (k < 75) begin
        dnib = NIB_EXT1;
        dext.push_back(8'($urandom));
      end else begin
        dnib = NIB_EXT2;
        dext.push_back(8'($urandom));
        dext.push_back(8'($urandom));
      end
      k = $urandom_range(0, 99);
      if (k < 70) begin
        lnib = 4'($urandom_range(0, 12));
        vlen = lnib;
      end else if (k < 92) begin
        lnib = NIB_EXT1;
        lext.push_back(8'($urandom_range(0, 20)));
        vlen = 13 + lext[0];
      end else begin
        lnib = NIB_EXT2;
        lext.push_back(8'h00);
        lext.push_back(8'($urandom_range(0, 30)));
        vlen = 269 + lext[1];
      end
      msg_bytes.push_back({dnib, lnib});
      foreach (dext[i]) msg_bytes.push_back(dext[i]);
      foreach (lext[i]) msg_bytes.push_back(lext[i]);
      repeat (vlen) msg_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 99) < 85) begin
      msg_bytes.push_back(MARKER_BYTE);
      repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
    end
  endtask

  byte_row_t directed_rows[] = '{
    // bad version, then a byte ignored after the error
    '{8'h00, 1'b0, 1'b1, CLS_FIXED,   STAT_ERROR},
    '{8'hc8, 1'b1, 1'b1, CLS_IGNORED, STAT_ERROR},
    // token length above the limit
    '{8'h49, 1'b1, 1'b1, CLS_FIXED,   STAT_ERROR},
    // full message: token, one-byte delta extension, value, two-byte delta wrap, payload
    '{8'h61, 1'b0, 1'b1, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'haa, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hd1, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h77, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'he0, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b1, 1'b1, CLS_PAYLOAD, STAT_OK},
    // reserved length nibble
    '{8'h40, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h3f, 1'b1, 1'b1, CLS_OPT_HDR, STAT_ERROR},
    // marker on the final byte
    '{8'h40, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'h00, 1'b0, 1'b0, CLS_FIXED,   STAT_PARSING},
    '{8'hff, 1'b1, 1'b1, CLS_MARKER,  STAT_OK}
  };

  function automatic bit field_ok(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  chp_result_t got_res;
  chp_result_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.byte_class    = out_tuser[2:0];
      got_res.option_ready  = out_tuser[3];
      got_res.option_number = out_tdata[15:0];
      got_res.option_length = out_tdata[31:16];
      got_res.message_type  = out_tdata[33:32];
      got_res.token_count   = out_tdata[37:34];
      got_res.header_code   = out_tdata[45:38];
      got_res.message_id    = out_tdata[61:46];
      got_res.status        = out_tdata[63:62];
      if (pending_byte_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual 0x%0h / 0x%0h",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want_res = pending_byte_results.pop_front();
        results_checked++;
        if (!(field_ok("byte_class", want_res.byte_class, got_res.byte_class)
            & field_ok("option_ready", want_res.option_ready, got_res.option_ready)
            & field_ok("option_number", want_res.option_number, got_res.option_number)
            & field_ok("option_length", want_res.option_length, got_res.option_length)
            & field_ok("message_type", want_res.message_type, got_res.message_type)
            & field_ok("token_count", want_res.token_count, got_res.token_count)
            & field_ok("header_code", want_res.header_code, got_res.header_code)
            & field_ok("message_id", want_res.message_id, got_res.message_id)
            & field_ok("status", want_res.status, got_res.status)))
          mismatches++;
      end
    end
    out_tready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int k;
    int msgs;
    int wait_cycles;
    clear_parser();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].cls, directed_rows[i].st);
    drain_results();

    msgs = 0;
    while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
      quiet = (items_sent >= 700 && items_sent < 1000);
      k = $urandom_range(0, 99);
      if (k < 75) begin
        compose_message();
      end else if (k < 88) begin
        compose_message();
        if ($urandom_range(0, 1) == 0)
          msg_bytes = msg_bytes[0:$urandom_range(0, msg_bytes.size() - 2)];
        else
          msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
      end else begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      end
      for (int i = 0; i < msg_bytes.size(); i++)
        send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msgs++;
      if (msgs % 40 == 0) drain_results();
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_byte_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_byte_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_byte_results.size());
      mismatches++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d messages, checked %0d results.",
             items_sent, messages_ok + messages_bad, results_checked);
    $display("%0d messages reached the marker, %0d ended in error, %0d options decoded.",
             messages_ok, messages_bad, options_decoded);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
